// ----- design/fuzzy_peer_group_median_filter_assert.svh -----
// Assertion macros shared by the checker of the peer-group median filter.
// Stand-alone header; users include it by its bare name.
`ifndef FUZZY_PEER_GROUP_MEDIAN_FILTER_ASSERT_SVH
`define FUZZY_PEER_GROUP_MEDIAN_FILTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FPG_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define FPG_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// ----- design/fpgmf_pkg.sv -----
// Package of the peer-group median filter: pixel type, register indexes,
// similarity test and nine-value median. Used by the top level, configuration, window and detection modules.
package fpgmf_pkg;
   typedef logic [7:0] chan_type;
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;
   typedef pixel_type window_type [9];

   typedef enum logic [2:0] {
      REG_OFFSET_K = 3'd0,
      REG_RATIO_NUM = 3'd1,
      REG_RATIO_DEN = 3'd2,
      REG_PEER_LIMIT = 3'd3,
      REG_IMAGE_WIDTH = 3'd4,
      REG_IMAGE_HEIGHT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [11:0] offset_k;
      logic [7:0] ratio_num;
      logic [7:0] ratio_den;
      logic [3:0] peer_limit;
   } detect_cfg_type;

   localparam int unsigned HEIGHT_CAP = 4096;

   // One channel is similar when den*(min+k) > num*(max+k).
   function automatic logic chan_similar(input chan_type x, input chan_type y,
                                         input detect_cfg_type cfg);
      logic [12:0] lo;
      logic [12:0] hi;
      logic [20:0] lhs;
      logic [20:0] rhs;
      lo = (x < y) ? {5'd0, x} : {5'd0, y};
      hi = (x < y) ? {5'd0, y} : {5'd0, x};
      lo = lo + {1'b0, cfg.offset_k};
      hi = hi + {1'b0, cfg.offset_k};
      lhs = 21'(cfg.ratio_den) * 21'(lo);
      rhs = 21'(cfg.ratio_num) * 21'(hi);
      return lhs > rhs;
   endfunction

   // Median of nine as a count of rank: the element whose rank, ties broken by
   // position, is four.
   function automatic chan_type median9(input chan_type v [9]);
      logic [3:0] rank;
      chan_type result;
      result = v[0];
      for (int i = 0; i < 9; i++) begin
         rank = '0;
         for (int j = 0; j < 9; j++) begin
            if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
               rank = rank + 4'd1;
            end
         end
         if (rank == 4'd4) begin
            result = v[i];
         end
      end
      return result;
   endfunction
endpackage

// ----- design/fuzzy_peer_group_median_filter.sv -----
// Fuzzy peer-group impulse detector with 3x3 median replacement.
// The result of an accepted interior pixel beat is registered and offered in the cycle after.
// Throughput: one pixel per cycle while the output register is empty or drained; it holds one result.
// Reset clears the output valid flag, position and window columns and loads the default
// configuration; the line stores are not cleared and fill as pixels arrive.
module fuzzy_peer_group_median_filter import fpgmf_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,  // in_red[7:0], in_green[15:8], in_blue[23:16]
   input  logic req_tuser,         // frame_start
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,  // out_red, out_green, out_blue, is_noise
   output logic rsp_tlast,         // frame_end
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data
);
   localparam int WW = $clog2(MAX_WIDTH+1);
   detect_cfg_type detect_cfg;
   logic [WW-1:0] width_sat;
   logic [12:0] height_sat;
   pixel_type pixel;
   pixel_type win [9];
   pixel_type result;
   logic interior, last_pixel, noisy, advance;
   logic valid_ff;
   logic [31:0] data_ff;
   logic last_ff;

   assign pixel = '{red: req_tdata[7:0], green: req_tdata[15:8], blue: req_tdata[23:16]};
   assign req_tready = !valid_ff || rsp_tready;
   assign advance = req_tvalid && req_tready;

   fpgmf_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .detect_cfg, .width_sat, .height_sat
   );

   fpgmf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock, .reset, .advance, .pixel, .frame_start(req_tuser),
      .width_sat, .height_sat, .win, .interior, .last_pixel
   );

   fpgmf_detect u_detect (.win, .cfg(detect_cfg), .result, .noisy);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= advance && interior;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= {7'd0, noisy, result.blue, result.green, result.red};
         last_ff <= last_pixel;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;
endmodule

// ----- design/fpgmf_cfg.sv -----
// Configuration registers of the peer-group median filter, with size saturation.
// Depends on fpgmf_pkg.
module fpgmf_cfg import fpgmf_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_data,
   output detect_cfg_type detect_cfg,
   output logic [$clog2(MAX_WIDTH+1)-1:0] width_sat,
   output logic [12:0] height_sat
);
   localparam int WW = $clog2(MAX_WIDTH+1);
   detect_cfg_type cfg_ff;
   logic [10:0] width_ff;
   logic [12:0] height_ff;

   assign csr_ready = 1'b1;
   assign detect_cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{offset_k: 12'd1024, ratio_num: 8'd19, ratio_den: 8'd20,
                     peer_limit: 4'd2};
         width_ff <= 11'd640;
         height_ff <= 13'd480;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_OFFSET_K: cfg_ff.offset_k <= csr_data[11:0];
            REG_RATIO_NUM: cfg_ff.ratio_num <= csr_data[7:0];
            REG_RATIO_DEN: cfg_ff.ratio_den <= csr_data[7:0];
            REG_PEER_LIMIT: cfg_ff.peer_limit <= csr_data[3:0];
            REG_IMAGE_WIDTH: width_ff <= csr_data[10:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < 11'd3) begin
         width_sat = WW'(3);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_sat = WW'(MAX_WIDTH);
      end else begin
         width_sat = WW'(width_ff);
      end
      if (height_ff < 13'd3) begin
         height_sat = 13'd3;
      end else if (32'(height_ff) > HEIGHT_CAP) begin
         height_sat = 13'(HEIGHT_CAP);
      end else begin
         height_sat = height_ff;
      end
   end
endmodule

// ----- design/fpgmf_window.sv -----
// Line stores, 3x3 window columns and raster position tracking.
// Depends on fpgmf_pkg.
module fpgmf_window import fpgmf_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  pixel_type pixel,
   input  logic frame_start,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] width_sat,
   input  logic [12:0] height_sat,
   output pixel_type win [9],
   output logic interior,
   output logic last_pixel
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH+1);

   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];
   pixel_type cols_ff [6];
   logic [AW-1:0] col_ff;
   logic [11:0] row_ff;
   logic [AW-1:0] col_in;
   logic [11:0] row_in;
   logic [AW-1:0] col_cur;
   logic [11:0] row_cur;
   logic first_ff;
   pixel_type up_rd_ff;
   pixel_type mid_rd_ff;
   pixel_type up_q;
   pixel_type mid_q;
   pixel_type fwd_up_ff;
   pixel_type fwd_mid_ff;
   logic fwd_ff;
   logic [AW-1:0] rd_addr;
   pixel_type up0_ff;
   pixel_type mid0_ff;

   // Position of the beat in flight; a frame start forces the origin.
   assign col_cur = frame_start ? '0 : col_ff;
   assign row_cur = frame_start ? '0 : row_ff;

   always_comb begin
      if ((WW'(col_cur) + WW'(1)) >= width_sat) begin
         col_in = '0;
         row_in = ((13'(row_cur) + 13'd1) >= height_sat) ? '0 : row_cur + 12'd1;
      end else begin
         col_in = col_cur + AW'(1);
         row_in = row_cur;
      end
   end

   // The stores are read one beat ahead at the next position; a read that
   // targets the entry just written is forwarded. A frame start jumps to the
   // origin, whose entries are mirrored in registers.
   always_comb begin
      rd_addr = advance ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         upper_mem[col_cur] <= mid_q;
         middle_mem[col_cur] <= pixel;
      end
      up_rd_ff <= upper_mem[rd_addr];
      mid_rd_ff <= middle_mem[rd_addr];
      fwd_up_ff <= mid_q;
      fwd_mid_ff <= pixel;
      fwd_ff <= advance && (rd_addr == col_cur);
   end

   // Copy of entry zero of both stores, kept up to date on every write there.
   always_ff @(posedge clock) begin
      if (advance && (col_cur == '0)) begin
         up0_ff <= mid_q;
         mid0_ff <= pixel;
      end
   end

   always_comb begin
      if (frame_start) begin
         up_q = up0_ff;
         mid_q = mid0_ff;
      end else if (fwd_ff) begin
         up_q = fwd_up_ff;
         mid_q = fwd_mid_ff;
      end else begin
         up_q = up_rd_ff;
         mid_q = mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         first_ff <= 1'b1;
         for (int i = 0; i < 6; i++) begin
            cols_ff[i] <= '0;
         end
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
         first_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cols_ff[i] <= cols_ff[3+i];
         end
         cols_ff[3] <= up_q;
         cols_ff[4] <= mid_q;
         cols_ff[5] <= pixel;
      end
   end

   always_comb begin
      win[0] = cols_ff[0]; win[1] = cols_ff[3]; win[2] = up_q;
      win[3] = cols_ff[1]; win[4] = cols_ff[4]; win[5] = mid_q;
      win[6] = cols_ff[2]; win[7] = cols_ff[5]; win[8] = pixel;
      interior = (row_cur >= 12'd2) && (col_cur >= AW'(2)) && !first_ff;
      last_pixel = (13'(row_cur) == height_sat - 13'd1) &&
                   (WW'(col_cur) == width_sat - WW'(1));
   end
endmodule

// ----- design/fpgmf_detect.sv -----
// Peer-group noise decision and per-channel median selection for one window.
// Depends on fpgmf_pkg.
module fpgmf_detect import fpgmf_pkg::*; (
   input  pixel_type win [9],
   input  detect_cfg_type cfg,
   output pixel_type result,
   output logic noisy
);
   logic [3:0] count;
   chan_type vr [9];
   chan_type vg [9];
   chan_type vb [9];

   always_comb begin
      count = '0;
      for (int i = 0; i < 9; i++) begin
         vr[i] = win[i].red;
         vg[i] = win[i].green;
         vb[i] = win[i].blue;
         if (chan_similar(win[i].red, win[4].red, cfg) &&
             chan_similar(win[i].green, win[4].green, cfg) &&
             chan_similar(win[i].blue, win[4].blue, cfg)) begin
            count = count + 4'd1;
         end
      end
      noisy = count <= cfg.peer_limit;
      if (noisy) begin
         result.red = median9(vr);
         result.green = median9(vg);
         result.blue = median9(vb);
      end else begin
         result = win[4];
      end
   end
endmodule

// ----- design/fpgmf_checker.sv -----
// Port-level checker for the peer-group median filter, bound to the top level.
// Depends on fuzzy_peer_group_median_filter_assert.svh.
`include "fuzzy_peer_group_median_filter_assert.svh"
module fpgmf_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic rsp_tlast
);
   `FPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")
   `FPG_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "input stalled with empty output")
   `FPG_ASSERT_NEXT(a_no_spurious, clock, reset, !(req_tvalid && req_tready) && !(rsp_tvalid && !rsp_tready), !rsp_tvalid, "result without input beat")
   `FPG_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[31:25] == 7'd0, "padding bits set")
endmodule

bind fuzzy_peer_group_median_filter fpgmf_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast
);
